/* rtl/core/rmb_pkg.sv */
// Shared widths, codes and types of the region-of-interest mean brightness block.
package rmb_pkg;

    localparam int MAX_DIMENSION_DEFAULT = 4096;

    localparam int CHAN_W   = 8;
    localparam int DIM_W    = 13;
    localparam int POS_W    = 12;
    localparam int COL_W    = 12;
    localparam int ROW_W    = 13;
    localparam int TOTAL_W  = 34;
    localparam int AREA_W   = 2 * DIM_W;
    localparam int LEVEL_W  = 10;
    localparam int DENOM_W  = AREA_W + LEVEL_W;
    localparam int FRAC_W   = 16;
    localparam int MEAN_W   = FRAC_W + 1;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [LEVEL_W-1:0] LEVELS_PER_PIXEL = LEVEL_W'(765);

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_FRAME  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_REGION = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SHORT      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_HEIGHT = 3'd5;

    localparam logic [MEAN_W-1:0] MEAN_FULL_SCALE = MEAN_W'(1) << FRAC_W;

    typedef struct packed {
        logic              done;
        logic [MEAN_W-1:0] quot;
    } t_div_rsp;

endpackage

/* rtl/core/rmb_if.sv */
// Valid/ready channel interfaces for pixel beats and result beats.
interface rmb_pix_if
    import rmb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              frame_end;

    modport source (output valid, output red, output green, output blue,
                    output frame_end, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input frame_end, output ready);
endinterface

interface rmb_res_if
    import rmb_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [MEAN_W-1:0]   mean_brightness;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output mean_brightness, output status, input ready);
    modport sink   (input valid, input mean_brightness, input status, output ready);
endinterface

/* rtl/core/rmb_div.sv */
// Restoring divider producing the saturated 16-fraction-bit ratio total/denominator.
module rmb_div
    import rmb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [TOTAL_W-1:0] i_dividend,
    input  logic [DENOM_W-1:0] i_divisor,
    output t_div_rsp           o_rsp
);

    localparam int CNT_W = $clog2(FRAC_W);

    logic               r_busy;
    logic               r_first;
    logic               r_sat;
    logic [CNT_W-1:0]   r_cnt;
    logic [DENOM_W-1:0] r_rem;
    logic [DENOM_W-1:0] r_div;
    logic [FRAC_W-1:0]  r_quot;

    logic [DENOM_W:0]   cmp_a;
    logic [DENOM_W+1:0] diff;
    logic               ge;
    logic               last_step;

    // The first pass only compares: a total at or above the divisor saturates.
    assign cmp_a     = r_first ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign diff      = {1'b0, cmp_a} - {2'b00, r_div};
    assign ge        = ~diff[DENOM_W+1];
    assign last_step = r_busy && ((r_first && ge) || (!r_first && r_cnt == CNT_W'(FRAC_W - 1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_first <= 1'b0;
            r_cnt   <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_first <= 1'b1;
            r_cnt   <= '0;
        end else if (r_busy) begin
            r_first <= 1'b0;
            if (!r_first) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (last_step) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= DENOM_W'(i_dividend);
            r_div  <= i_divisor;
            r_quot <= '0;
            r_sat  <= 1'b0;
        end else if (r_busy) begin
            if (r_first) begin
                r_sat <= ge;
            end else begin
                r_rem  <= ge ? diff[DENOM_W-1:0] : cmp_a[DENOM_W-1:0];
                r_quot <= {r_quot[FRAC_W-2:0], ge};
            end
        end
    end

    always_comb begin
        o_rsp.done = last_step;
        o_rsp.quot = r_sat ? MEAN_FULL_SCALE : {1'b0, r_quot};
    end

endmodule

/* rtl/core/roi_mean_brightness.sv */
// Mean brightness of a configured rectangle over one raster-order RGB frame.
//
// Pixels enter on i_pix in raster order, one beat per cycle while i_pix.ready
// is high; the block keeps its own column and row. Red, green and blue of
// pixels inside the rectangle are summed. The beat carrying frame_end produces
// one result beat on o_res: the mean channel level as a fraction of full
// scale in 16-fraction-bit fixed point, or a status code with a mean of zero.
// i_pix.ready stays high for ordinary pixels. After a frame_end beat it drops
// while the result is formed: the denominator product is registered in S_MUL1
// and S_MUL2, then the shift-and-subtract divider makes a compare pass and,
// unless the mean saturates at full scale, forms the 16 quotient bits. A
// valid frame's result is registered in S_OUT after the divider is done; an
// error result goes from S_IDLE straight to S_OUT. i_pix.ready returns as the
// result is registered. The result sits in an output register; when the
// receiver stalls it holds there and a new frame's pixels are still taken. A
// further frame_end beat is taken too, but the input then stays closed until
// the register drains. Reset clears the configuration, state, counters,
// running total and output valid flag. The user must write configuration
// through i_cfg_* while idle; the block itself does not enforce this.
module roi_mean_brightness
    import rmb_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rmb_pix_if.sink              i_pix,
    rmb_res_if.source            o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [DIM_W-1:0] r_frame_width;
    logic [DIM_W-1:0] r_frame_height;
    logic [POS_W-1:0] r_region_left;
    logic [POS_W-1:0] r_region_top;
    logic [DIM_W-1:0] r_region_width;
    logic [DIM_W-1:0] r_region_height;

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    logic [COL_W-1:0]    r_col;
    logic [COL_W-1:0]    n_col;
    logic [ROW_W-1:0]    r_row;
    logic [ROW_W-1:0]    n_row;
    logic [TOTAL_W-1:0]  r_total;
    logic [TOTAL_W-1:0]  n_total;
    logic [TOTAL_W-1:0]  r_total_lat;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    logic [AREA_W-1:0]   r_area;
    logic                r_out_valid;
    logic [MEAN_W-1:0]   r_out_mean;
    logic [STATUS_W-1:0] r_out_status;

    logic               accept;
    logic               frame_ok;
    logic               region_ok;
    logic               counting;
    logic               in_region;
    logic [DIM_W:0]     col_end;
    logic [DIM_W:0]     row_end;
    logic [LEVEL_W-1:0] pix_sum;
    logic [DIM_W-1:0]   col_inc;
    logic               out_free;
    logic               div_start;
    logic [DENOM_W-1:0] denom;
    t_div_rsp           div_rsp;

    assign accept   = i_pix.valid && i_pix.ready;
    assign out_free = !r_out_valid || o_res.ready;

    assign frame_ok = (r_frame_width != '0) && (r_frame_height != '0) &&
                      (32'(r_frame_width) <= 32'(MAX_DIMENSION)) &&
                      (32'(r_frame_height) <= 32'(MAX_DIMENSION));

    assign col_end = (DIM_W + 1)'(r_region_left) + (DIM_W + 1)'(r_region_width);
    assign row_end = (DIM_W + 1)'(r_region_top) + (DIM_W + 1)'(r_region_height);

    assign region_ok = (r_region_width != '0) && (r_region_height != '0) &&
                       (col_end <= (DIM_W + 1)'(r_frame_width)) &&
                       (row_end <= (DIM_W + 1)'(r_frame_height));

    assign counting  = frame_ok && (r_row < r_frame_height);
    assign in_region = (r_col >= r_region_left) &&
                       ((DIM_W + 1)'(r_col) < col_end) &&
                       (r_row >= ROW_W'(r_region_top)) &&
                       ((DIM_W + 1)'(r_row) < row_end);
    assign pix_sum   = LEVEL_W'(i_pix.red) + LEVEL_W'(i_pix.green) + LEVEL_W'(i_pix.blue);
    assign col_inc   = DIM_W'(r_col) + DIM_W'(1);

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_total = r_total;
        if (counting) begin
            if (in_region) begin
                n_total = r_total + TOTAL_W'(pix_sum);
            end
            // A column at or past the frame width wraps to the next row.
            if (col_inc >= r_frame_width) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = col_inc[COL_W-1:0];
            end
        end
    end

    always_comb begin
        priority if (!frame_ok) begin
            n_status = ST_BAD_FRAME;
        end else if (!region_ok) begin
            n_status = ST_BAD_REGION;
        end else if (n_row < r_frame_height) begin
            n_status = ST_SHORT;
        end else begin
            n_status = ST_OK;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_pix.frame_end) begin
                    n_state = (n_status == ST_OK) ? S_MUL1 : S_OUT;
                end
            end
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_DIV;
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= '0;
            r_frame_height  <= '0;
            r_region_left   <= '0;
            r_region_top    <= '0;
            r_region_width  <= '0;
            r_region_height <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data;
                CFG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data;
                CFG_REGION_LEFT:   r_region_left   <= i_cfg_data[POS_W-1:0];
                CFG_REGION_TOP:    r_region_top    <= i_cfg_data[POS_W-1:0];
                CFG_REGION_WIDTH:  r_region_width  <= i_cfg_data;
                CFG_REGION_HEIGHT: r_region_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                if (i_pix.frame_end) begin
                    r_col   <= '0;
                    r_row   <= '0;
                    r_total <= '0;
                end else begin
                    r_col   <= n_col;
                    r_row   <= n_row;
                    r_total <= n_total;
                end
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_pix.frame_end) begin
            r_total_lat <= n_total;
            r_status    <= n_status;
        end
        if (r_state == S_MUL1) begin
            r_area <= AREA_W'(r_region_width) * AREA_W'(r_region_height);
        end
        if (r_state == S_OUT && out_free) begin
            r_out_status <= r_status;
            r_out_mean   <= (r_status == ST_OK) ? div_rsp.quot : '0;
        end
    end

    assign div_start = (r_state == S_MUL2);
    assign denom     = DENOM_W'(r_area) * DENOM_W'(LEVELS_PER_PIXEL);

    rmb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_total_lat),
        .i_divisor  (denom),
        .o_rsp      (div_rsp)
    );

    assign i_pix.ready           = (r_state == S_IDLE);
    assign o_res.valid           = r_out_valid;
    assign o_res.mean_brightness = r_out_mean;
    assign o_res.status          = r_out_status;

endmodule

/* rtl/core/rmb_chk.sv */
// Port-level assertions for the mean brightness block, bound to the top level.
module rmb_chk
    import rmb_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_pix_valid,
    input logic                i_pix_ready,
    input logic                i_pix_frame_end,
    input logic                i_res_valid,
    input logic                i_res_ready,
    input logic [MEAN_W-1:0]   i_res_mean,
    input logic [STATUS_W-1:0] i_res_status
);

    // Any error status carries a zero mean.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_status != ST_OK) |-> (i_res_mean == '0))
        else $error("error status with non-zero mean");

    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_mean <= MEAN_FULL_SCALE))
        else $error("mean above full scale");

    // The pixel channel closes after a frame_end beat while the result is formed.
    a_end_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix_valid && i_pix_ready && i_pix_frame_end) |=> !i_pix_ready)
        else $error("pixel beat taken straight after frame end");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_res_mean) && $stable(i_res_status)))
        else $error("stalled result beat changed");

endmodule

bind roi_mean_brightness rmb_chk u_rmb_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_pix_valid     (i_pix.valid),
    .i_pix_ready     (i_pix.ready),
    .i_pix_frame_end (i_pix.frame_end),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_res_mean      (o_res.mean_brightness),
    .i_res_status    (o_res.status)
);

/* tb/sv/roi_mean_brightness_tb.sv */
// Self-checking bench for roi_mean_brightness: predicted frame means compared with result beats.
module roi_mean_brightness_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmb_pkg::*;

    localparam int CLK_PERIOD        = 4;
    localparam int CYCLE_LIMIT       = 500_000;
    localparam int SETTLE_CYCLES     = 32;
    localparam int RANDOM_PIXELS     = 730;
    localparam int RANDOM_FRAMES_MIN = 40;
    localparam int HOLD_CYCLES       = 200;
    localparam int FULL_EDGE         = 4096;
    localparam int BLOCK_EDGE        = 16;

    // Indexes past the last register; writes to them must leave everything alone.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum int {LEVELS_RANDOM, LEVELS_FULL, LEVELS_DARK} t_level_mode;

    typedef struct packed {
        logic [MEAN_W-1:0]   mean_brightness;
        logic [STATUS_W-1:0] status;
    } t_roi_result;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    rmb_pix_if pix ();
    rmb_res_if res ();

    roi_mean_brightness uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_pix       (pix),
        .o_res       (res),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Mirror of the block's registers and frame state.
    logic [DIM_W-1:0]   frame_w_reg;
    logic [DIM_W-1:0]   frame_h_reg;
    logic [POS_W-1:0]   region_l_reg;
    logic [POS_W-1:0]   region_t_reg;
    logic [DIM_W-1:0]   region_w_reg;
    logic [DIM_W-1:0]   region_h_reg;
    logic [COL_W-1:0]   col_pos;
    logic [ROW_W-1:0]   row_pos;
    logic [TOTAL_W-1:0] level_sum;

    t_roi_result brightness_due[$];

    int mismatch_count = 0;
    int pixels_sent    = 0;
    int cycle_count    = 0;
    int sink_hold      = 0;
    bit src_idle       = 1'b1;
    bit sink_idle      = 1'b1;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    function automatic bit roi_accumulate(input logic [CHAN_W-1:0] r, g, b, input logic last,
                                          output t_roi_result outcome);
        bit                frame_ok;
        bit                region_ok;
        longint unsigned   area_levels;
        longint unsigned   quotient;
        frame_ok = frame_w_reg != 0 && frame_h_reg != 0 &&
                   frame_w_reg <= MAX_DIMENSION_DEFAULT && frame_h_reg <= MAX_DIMENSION_DEFAULT;
        outcome = '0;
        // Pixels past the last row, or of an invalid frame, are not counted at all.
        if (frame_ok && row_pos < frame_h_reg) begin
            if (col_pos >= region_l_reg &&
                col_pos < int'(region_l_reg) + int'(region_w_reg) &&
                row_pos >= region_t_reg &&
                row_pos < int'(region_t_reg) + int'(region_h_reg)) begin
                level_sum = level_sum + r + g + b;
            end
            if (col_pos + 1 >= frame_w_reg) begin
                col_pos = '0;
                row_pos = row_pos + 1'b1;
            end else begin
                col_pos = col_pos + 1'b1;
            end
        end
        if (!last)
            return 1'b0;
        region_ok = region_w_reg != 0 && region_h_reg != 0 &&
                    int'(region_l_reg) + int'(region_w_reg) <= int'(frame_w_reg) &&
                    int'(region_t_reg) + int'(region_h_reg) <= int'(frame_h_reg);
        if (!frame_ok) begin
            outcome.status = ST_BAD_FRAME;
        end else if (!region_ok) begin
            outcome.status = ST_BAD_REGION;
        end else if (row_pos < frame_h_reg) begin
            outcome.status = ST_SHORT;
        end else begin
            outcome.status = ST_OK;
            area_levels = region_w_reg;
            area_levels = area_levels * region_h_reg * LEVELS_PER_PIXEL;
            quotient = {level_sum, 16'b0};
            quotient = quotient / area_levels;
            if (quotient > MEAN_FULL_SCALE)
                quotient = MEAN_FULL_SCALE;
            outcome.mean_brightness = quotient[MEAN_W-1:0];
        end
        col_pos   = '0;
        row_pos   = '0;
        level_sum = '0;
        return 1'b1;
    endfunction

    // Called at a rising edge or a falling edge; leaves the beat just accepted.
    task automatic send_pixel(input logic [CHAN_W-1:0] r, g, b, input logic last);
        int          gap;
        t_roi_result outcome;
        gap = src_idle ? $urandom_range(0, 6) : 0;
        @(negedge clk);
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix.valid     <= 1'b1;
        pix.red       <= r;
        pix.green     <= g;
        pix.blue      <= b;
        pix.frame_end <= last;
        do @(posedge clk); while (!pix.ready);
        if (roi_accumulate(r, g, b, last, outcome))
            brightness_due = {brightness_due, outcome};
        pixels_sent++;
    endtask

    task automatic send_frame(input int count, input bit marked, input t_level_mode mode);
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        for (int i = 0; i < count; i++) begin
            case (mode)
                LEVELS_FULL: {r, g, b} = '1;
                LEVELS_DARK: {r, g, b} = '0;
                default: begin
                    r = $urandom_range(0, 255);
                    g = $urandom_range(0, 255);
                    b = $urandom_range(0, 255);
                end
            endcase
            send_pixel(r, g, b, marked && i == count - 1);
        end
    endtask

    // Stops offering pixels and waits until the block has nothing left to report.
    task automatic settle();
        @(negedge clk);
        pix.valid <= 1'b0;
        while (brightness_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_FRAME_WIDTH:   frame_w_reg  = data;
            CFG_FRAME_HEIGHT:  frame_h_reg  = data;
            CFG_REGION_LEFT:   region_l_reg = data[POS_W-1:0];
            CFG_REGION_TOP:    region_t_reg = data[POS_W-1:0];
            CFG_REGION_WIDTH:  region_w_reg = data;
            CFG_REGION_HEIGHT: region_h_reg = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_geometry(input logic [DIM_W-1:0] fw, fh, rl, rt, rw, rh);
        settle();
        write_reg(CFG_FRAME_WIDTH, fw);
        write_reg(CFG_FRAME_HEIGHT, fh);
        write_reg(CFG_REGION_LEFT, rl);
        write_reg(CFG_REGION_TOP, rt);
        write_reg(CFG_REGION_WIDTH, rw);
        write_reg(CFG_REGION_HEIGHT, rh);
    endtask

    // Every register still holds zero, so the frame size is invalid.
    task automatic test_after_reset();
        send_frame(1, 1'b1, LEVELS_RANDOM);
    endtask

    task automatic test_status_codes();
        program_geometry(13'd4097, 13'd1, 13'd0, 13'd0, 13'd1, 13'd1);
        send_frame(1, 1'b1, LEVELS_RANDOM);
        settle();
        write_reg(CFG_FRAME_WIDTH, 13'd8191);
        send_frame(1, 1'b1, LEVELS_RANDOM);
        program_geometry(13'd4, 13'd0, 13'd0, 13'd0, 13'd1, 13'd1);
        send_frame(1, 1'b1, LEVELS_RANDOM);
        program_geometry(13'd4, 13'd2, 13'd0, 13'd0, 13'd0, 13'd1);
        send_frame(1, 1'b1, LEVELS_RANDOM);
        program_geometry(13'd4, 13'd2, 13'd0, 13'd0, 13'd1, 13'd0);
        send_frame(1, 1'b1, LEVELS_RANDOM);
        // Rectangle one column past the right edge, then one row past the bottom.
        program_geometry(13'd4, 13'd2, 13'd3, 13'd0, 13'd2, 13'd1);
        send_frame(1, 1'b1, LEVELS_RANDOM);
        program_geometry(13'd4, 13'd2, 13'd0, 13'd1, 13'd1, 13'd2);
        send_frame(1, 1'b1, LEVELS_RANDOM);
        program_geometry(13'd4, 13'd2, 13'd0, 13'd0, 13'd4, 13'd2);
        send_frame(3, 1'b1, LEVELS_RANDOM);
        // A bad frame size outranks a bad rectangle.
        program_geometry(13'd0, 13'd2, 13'd0, 13'd0, 13'd0, 13'd1);
        send_frame(1, 1'b1, LEVELS_RANDOM);
    endtask

    task automatic test_special_frames();
        // The top bit of the data is dropped for the 12-bit position registers.
        program_geometry(13'd4, 13'd1, 13'h1003, 13'h1000, 13'd1, 13'd1);
        write_reg(CFG_SPARE_LO, 13'h0000);
        write_reg(CFG_SPARE_HI, 13'h1FFF);
        send_frame(4, 1'b1, LEVELS_RANDOM);
        program_geometry(13'd2, 13'd1, 13'd0, 13'd0, 13'd2, 13'd1);
        send_frame(2, 1'b1, LEVELS_FULL);
        // Pixels after the last row are ignored, the frame end among them.
        program_geometry(13'd1, 13'd1, 13'd0, 13'd0, 13'd1, 13'd1);
        send_frame(3, 1'b1, LEVELS_RANDOM);
        // Narrowing the frame mid-row wraps the column that is already too far.
        program_geometry(13'd3, 13'd2, 13'd0, 13'd0, 13'd2, 13'd2);
        send_frame(2, 1'b0, LEVELS_RANDOM);
        settle();
        write_reg(CFG_FRAME_WIDTH, 13'd2);
        send_frame(2, 1'b1, LEVELS_RANDOM);
    endtask

    // The largest frame edges, with the rectangle against the far edge; these frames
    // end early. A complete mid-sized frame then runs the divider through every bit.
    task automatic test_extreme_sizes();
        src_idle = 1'b0;
        program_geometry(DIM_W'(FULL_EDGE), 13'd1, DIM_W'(FULL_EDGE - 1), 13'd0,
                         13'd1, 13'd1);
        send_frame(8, 1'b1, LEVELS_RANDOM);
        program_geometry(13'd1, DIM_W'(FULL_EDGE), 13'd0, DIM_W'(FULL_EDGE - 1),
                         13'd1, 13'd1);
        send_frame(8, 1'b1, LEVELS_RANDOM);
        program_geometry(DIM_W'(FULL_EDGE), DIM_W'(FULL_EDGE), 13'd0, 13'd0,
                         DIM_W'(FULL_EDGE), DIM_W'(FULL_EDGE));
        send_frame(4, 1'b1, LEVELS_RANDOM);
        // One column too wide for the largest frame.
        program_geometry(DIM_W'(FULL_EDGE), 13'd1, DIM_W'(FULL_EDGE - 1), 13'd0,
                         13'd2, 13'd1);
        send_frame(2, 1'b1, LEVELS_RANDOM);
        program_geometry(DIM_W'(BLOCK_EDGE), DIM_W'(BLOCK_EDGE), 13'd3, 13'd2,
                         13'd10, 13'd12);
        send_frame(BLOCK_EDGE * BLOCK_EDGE, 1'b1, LEVELS_RANDOM);
        src_idle = 1'b1;
    endtask

    // The receiver stops for a long while, so one result waits in the output register
    // and the next frame end has to stall the pixel input.
    task automatic test_backpressure();
        program_geometry(13'd3, 13'd1, 13'd0, 13'd0, 13'd3, 13'd1);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        sink_hold = HOLD_CYCLES;
        repeat (6) send_frame(3, 1'b1, LEVELS_RANDOM);
        settle();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    task automatic test_random_frames();
        int          first_pixel;
        int          frames_ended;
        int          kind;
        int          fw;
        int          fh;
        int          rl;
        int          rt;
        int          rw;
        int          rh;
        int          count;
        bit          marked;
        t_level_mode mode;
        first_pixel  = pixels_sent;
        frames_ended = 0;
        while (pixels_sent - first_pixel < RANDOM_PIXELS || frames_ended < RANDOM_FRAMES_MIN) begin
            src_idle  = $urandom_range(0, 3) != 0;
            sink_idle = $urandom_range(0, 3) != 0;
            kind = $urandom_range(0, 19);
            fw = $urandom_range(1, 8);
            fh = $urandom_range(1, 6);
            rw = $urandom_range(1, fw);
            rh = $urandom_range(1, fh);
            rl = $urandom_range(0, fw - rw);
            rt = $urandom_range(0, fh - rh);
            count  = fw * fh;
            marked = 1'b1;
            case (kind)
                0: begin
                    case ($urandom_range(0, 3))
                        0: fw = 0;
                        1: fh = 0;
                        2: fw = $urandom_range(FULL_EDGE + 1, 8191);
                        default: fh = $urandom_range(FULL_EDGE + 1, 8191);
                    endcase
                    count = $urandom_range(1, 4);
                end
                1: begin
                    case ($urandom_range(0, 3))
                        0: rw = 0;
                        1: rh = 0;
                        2: rl = fw - rw + 1;
                        default: rt = fh - rh + 1;
                    endcase
                end
                2: if (count > 1) count = $urandom_range(1, count - 1);
                3: count += $urandom_range(1, 3);
                // The frame is left open; the next setting picks up its counters.
                4: marked = 1'b0;
                default: ;
            endcase
            case ($urandom_range(0, 7))
                0: mode = LEVELS_FULL;
                1: mode = LEVELS_DARK;
                default: mode = LEVELS_RANDOM;
            endcase
            program_geometry(DIM_W'(fw), DIM_W'(fh), DIM_W'(rl), DIM_W'(rt),
                             DIM_W'(rw), DIM_W'(rh));
            send_frame(count, marked, mode);
            if (marked)
                frames_ended++;
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        pix.valid     = 1'b0;
        pix.red       = '0;
        pix.green     = '0;
        pix.blue      = '0;
        pix.frame_end = 1'b0;
        frame_w_reg   = '0;
        frame_h_reg   = '0;
        region_l_reg  = '0;
        region_t_reg  = '0;
        region_w_reg  = '0;
        region_h_reg  = '0;
        col_pos       = '0;
        row_pos       = '0;
        level_sum     = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        test_after_reset();
        test_status_codes();
        test_special_frames();
        test_extreme_sizes();
        test_backpressure();
        test_random_frames();
        settle();
        if (mismatch_count == 0)
            $display("roi_mean_brightness_tb OK");
        else
            $display("roi_mean_brightness_tb NOT OK");
        $finish;
    end

    // Result receiver: a random pause before each beat while sink_idle is set, plus any long hold requested.
    initial begin : result_sink
        int stall;
        res.ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever begin
            stall = sink_idle ? $urandom_range(0, 6) : 0;
            stall += sink_hold;
            sink_hold = 0;
            if (stall > 0) begin
                res.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res.ready <= 1'b1;
            do @(posedge clk); while (!(res.valid && res.ready));
            @(negedge clk);
        end
    end

    always @(posedge clk) begin : check_results
        t_roi_result want;
        if (rst_n && res.valid && res.ready) begin
            if (brightness_due.size() == 0) begin
                report_mismatch($sformatf("result beat with none due: mean %0d status %0d",
                                          res.mean_brightness, res.status));
            end else begin
                want = brightness_due.pop_front();
                if (res.mean_brightness !== want.mean_brightness)
                    report_mismatch($sformatf("mean_brightness %0d, expected %0d",
                                              res.mean_brightness, want.mean_brightness));
                if (res.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              res.status, want.status));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("roi_mean_brightness_tb NOT OK");
            $finish;
        end
    end

endmodule
